/* rtl/spmq_pkg.sv */
package spmq_pkg;

    // Fixed field widths of the ports
    localparam int NL_W       = 4;
    localparam int TOTAL_W    = 11;
    localparam int OUT_EV_W   = 32;
    localparam int PRIO_W     = 8;
    localparam int POPCNT_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL  = 1'd1;

    localparam logic [NL_W-1:0]    NUM_LEVELS_RST = 4'd1;
    localparam logic [TOTAL_W-1:0] MAX_TOTAL_RST  = 11'd1024;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_PUSH,
        ST_POP_READ,
        ST_POP_LOAD
    } state_t;

    typedef enum logic [1:0] {
        LOP_NONE,
        LOP_PUSH,
        LOP_POP,
        LOP_FLUSH
    } lvl_op_t;

    typedef struct packed {
        lvl_op_t         op;
        logic [NL_W-1:0] lvl;
    } lvl_ctrl_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [NL_W-1:0]    first_lvl;
    } lvl_status_t;

endpackage

/* rtl/spmq_store.sv */
module spmq_store #(
    parameter int DEPTH  = 960,
    parameter int DATA_W = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rd_data_reg
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

endmodule

/* rtl/spmq_levels.sv */
module spmq_levels #(
    parameter int LEVEL_SLOTS = 64,
    parameter int MAX_LEVELS  = 15
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  spmq_pkg::lvl_ctrl_t                ctrl,
    output logic [$clog2(LEVEL_SLOTS)-1:0]     sel_head,
    output logic [$clog2(LEVEL_SLOTS)-1:0]     sel_tail,
    output logic [$clog2(LEVEL_SLOTS+1)-1:0]   sel_fill,
    output spmq_pkg::lvl_status_t              status
);

    localparam int IDX_W  = $clog2(LEVEL_SLOTS);
    localparam int FILL_W = $clog2(LEVEL_SLOTS + 1);
    localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    logic [IDX_W-1:0]             head_reg [MAX_LEVELS];
    logic [IDX_W-1:0]             tail_reg [MAX_LEVELS];
    logic [FILL_W-1:0]            fill_reg [MAX_LEVELS];
    logic [spmq_pkg::TOTAL_W-1:0] total_reg;
    logic [spmq_pkg::TOTAL_W-1:0] total_next;
    logic [spmq_pkg::TOTAL_W-1:0] delta;
    logic [LVL_W-1:0]             sel;
    logic [spmq_pkg::NL_W-1:0]    first_lvl;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] ix);
        return (ix == IDX_W'(LEVEL_SLOTS - 1)) ? '0 : ix + 1'b1;
    endfunction

    assign sel      = ctrl.lvl[LVL_W-1:0];
    assign sel_head = head_reg[sel];
    assign sel_tail = tail_reg[sel];
    assign sel_fill = fill_reg[sel];

    // Shared adder for the total count
    always_comb
    begin
        unique case (ctrl.op)
            spmq_pkg::LOP_PUSH:  delta = spmq_pkg::TOTAL_W'(1);
            spmq_pkg::LOP_POP:   delta = '1;
            spmq_pkg::LOP_FLUSH: delta = ~spmq_pkg::TOTAL_W'(sel_fill) + 1'b1;
            spmq_pkg::LOP_NONE:  delta = '0;
        endcase
        total_next = total_reg + delta;
    end

    // Lowest-numbered non-empty level
    always_comb
    begin
        first_lvl = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--)
        begin
            if (fill_reg[i] != '0)
            begin
                first_lvl = spmq_pkg::NL_W'(i);
            end
        end
    end

    assign status = '{total: total_reg, first_lvl: first_lvl};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            total_reg <= total_next;
            unique case (ctrl.op)
                spmq_pkg::LOP_PUSH:
                begin
                    tail_reg[sel] <= wrap_inc(tail_reg[sel]);
                    fill_reg[sel] <= fill_reg[sel] + 1'b1;
                end
                spmq_pkg::LOP_POP:
                begin
                    head_reg[sel] <= wrap_inc(head_reg[sel]);
                    fill_reg[sel] <= fill_reg[sel] - 1'b1;
                end
                spmq_pkg::LOP_FLUSH:
                begin
                    head_reg[sel] <= '0;
                    tail_reg[sel] <= '0;
                    fill_reg[sel] <= '0;
                end
                spmq_pkg::LOP_NONE:
                begin
                end
            endcase
        end
    end

endmodule

/* rtl/strict_priority_multi_queue.sv */
// Strict priority queue of event handles, up to MAX_LEVELS levels of LEVEL_SLOTS entries each,
// all held in one single-port-read event memory. A push is accepted, then makes one memory
// write and loads the result. A pop is accepted and then returns each event through
// ST_POP_READ and ST_POP_LOAD, since each event needs one read of the event memory before it
// reaches the output register; a pop on an empty queue returns its single result from
// ST_POP_READ without a read. Input is taken only in the idle state; a request whose result
// meets a stalled output register holds in its state until the register frees, and no further
// request is taken meanwhile. Writing num_levels below MAX_LEVELS while idle starts a flush
// that clears one level per cycle, from num_levels to the last, during which no request is
// accepted. The event memory is not cleared at reset; per-level pointers and counts are.
module strict_priority_multi_queue #(
    parameter int LEVEL_SLOTS = 64,
    parameter int MAX_LEVELS  = 15,
    parameter int EVENT_BITS  = 32,
    parameter int MAX_POP     = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [spmq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spmq_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [31:0]                         event_data,
    input  logic [spmq_pkg::PRIO_W-1:0]         priority_req,
    input  logic [spmq_pkg::POPCNT_W-1:0]       pop_count,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                push_accepted,
    output logic [spmq_pkg::OUT_EV_W-1:0]       popped_event,
    output logic                                pop_valid,
    output logic                                last,
    output logic [spmq_pkg::TOTAL_W-1:0]        occupancy
);

    localparam int IDX_W  = $clog2(LEVEL_SLOTS);
    localparam int FILL_W = $clog2(LEVEL_SLOTS + 1);
    localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int DEPTH  = MAX_LEVELS * LEVEL_SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_POP + 1);
    localparam int NL_W   = spmq_pkg::NL_W;
    localparam int TOT_W  = spmq_pkg::TOTAL_W;

    spmq_pkg::state_t      state_reg, state_next;
    spmq_pkg::lvl_op_t     lvl_op;
    spmq_pkg::lvl_ctrl_t   lvl_ctrl;
    spmq_pkg::lvl_status_t status;

    logic [NL_W-1:0]       num_levels_reg;
    logic [TOT_W-1:0]      max_total_reg;
    logic [NL_W-1:0]       flush_ptr_reg, flush_ptr_next;
    logic [NL_W-1:0]       ptr_inc;

    logic                  op_reg, op_next;
    logic [EVENT_BITS-1:0] ev_reg, ev_next;
    logic [NL_W-1:0]       lvl_reg, lvl_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic                  last_pend_reg, last_pend_next;

    logic                  out_valid_reg;
    logic                  push_accepted_reg, push_accepted_next;
    logic [spmq_pkg::OUT_EV_W-1:0] popped_event_reg, popped_event_next;
    logic                  pop_valid_reg, pop_valid_next;
    logic                  last_reg, last_next;
    logic [TOT_W-1:0]      occupancy_reg, occupancy_next;
    logic                  out_load;
    logic                  out_free;

    logic [NL_W-1:0]       sel_lvl;
    logic [IDX_W-1:0]      sel_head, sel_tail;
    logic [FILL_W-1:0]     sel_fill;
    logic                  push_ok;
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [EVENT_BITS-1:0] rd_data;

    logic                  cfg_lv_write;
    logic [NL_W-1:0]       cfg_lv_value;
    logic [NL_W-1:0]       prio_clamped;
    logic [31:0]           want;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [NL_W-1:0] lv,
                                                    input logic [IDX_W-1:0] ix);
        return ADDR_W'(32'(lv[LVL_W-1:0]) * LEVEL_SLOTS + 32'(ix));
    endfunction

    // Configuration decode and saturation
    assign cfg_lv_write = cfg_we && (cfg_index == spmq_pkg::CFG_NUM_LEVELS);

    always_comb
    begin
        priority if (cfg_data[NL_W-1:0] == '0)
            cfg_lv_value = NL_W'(1);
        else if (32'(cfg_data[NL_W-1:0]) > MAX_LEVELS)
            cfg_lv_value = NL_W'(MAX_LEVELS);
        else
            cfg_lv_value = cfg_data[NL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_levels_reg <= spmq_pkg::NUM_LEVELS_RST;
            max_total_reg  <= spmq_pkg::MAX_TOTAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spmq_pkg::CFG_NUM_LEVELS: num_levels_reg <= cfg_lv_value;
                spmq_pkg::CFG_MAX_TOTAL:  max_total_reg  <= cfg_data[TOT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Request field shaping
    always_comb
    begin
        if (32'(priority_req) >= 32'(num_levels_reg))
            prio_clamped = num_levels_reg - 1'b1;
        else
            prio_clamped = priority_req[NL_W-1:0];

        priority if (pop_count == '0)
            want = 32'd1;
        else if (32'(pop_count) > MAX_POP)
            want = 32'(MAX_POP);
        else
            want = 32'(pop_count);
    end

    // Level bookkeeping and shared count unit
    always_comb
    begin
        unique case (state_reg)
            spmq_pkg::ST_FLUSH:    sel_lvl = flush_ptr_reg;
            spmq_pkg::ST_POP_READ: sel_lvl = status.first_lvl;
            default:               sel_lvl = lvl_reg;
        endcase
    end

    assign lvl_ctrl = '{op: lvl_op, lvl: sel_lvl};

    spmq_levels #(
        .LEVEL_SLOTS(LEVEL_SLOTS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_levels (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lvl_ctrl),
        .sel_head(sel_head),
        .sel_tail(sel_tail),
        .sel_fill(sel_fill),
        .status  (status)
    );

    assign push_ok = (status.total < max_total_reg) && (32'(sel_fill) < LEVEL_SLOTS);
    assign waddr   = slot_addr(lvl_reg, sel_tail);
    assign raddr   = slot_addr(status.first_lvl, sel_head);

    spmq_store #(
        .DEPTH (DEPTH),
        .DATA_W(EVENT_BITS)
    ) u_store (
        .clk        (clk),
        .we         (mem_we),
        .waddr      (waddr),
        .wdata      (ev_reg),
        .re         (mem_re),
        .raddr      (raddr),
        .rd_data_reg(rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign ptr_inc  = flush_ptr_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        flush_ptr_next     = flush_ptr_reg;
        op_next            = op_reg;
        ev_next            = ev_reg;
        lvl_next           = lvl_reg;
        rem_next           = rem_reg;
        last_pend_next     = last_pend_reg;
        in_ready           = 1'b0;
        lvl_op             = spmq_pkg::LOP_NONE;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        out_load           = 1'b0;
        push_accepted_next = push_accepted_reg;
        popped_event_next  = popped_event_reg;
        pop_valid_next     = pop_valid_reg;
        last_next          = last_reg;
        occupancy_next     = occupancy_reg;

        unique case (state_reg)
            spmq_pkg::ST_IDLE:
            begin
                if (cfg_lv_write && (32'(cfg_lv_value) < MAX_LEVELS))
                begin
                    flush_ptr_next = cfg_lv_value;
                    state_next     = spmq_pkg::ST_FLUSH;
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        op_next  = operation;
                        ev_next  = EVENT_BITS'(64'(event_data));
                        lvl_next = prio_clamped;
                        rem_next = CNT_W'(want);
                        state_next = (operation == spmq_pkg::OP_PUSH) ?
                                     spmq_pkg::ST_PUSH : spmq_pkg::ST_POP_READ;
                    end
                end
            end

            spmq_pkg::ST_FLUSH:
            begin
                lvl_op = spmq_pkg::LOP_FLUSH;
                // a later, lower level count restarts the sweep lower down
                if (cfg_lv_write && (cfg_lv_value < ptr_inc))
                    flush_ptr_next = cfg_lv_value;
                else
                    flush_ptr_next = ptr_inc;
                if (32'(flush_ptr_next) >= MAX_LEVELS)
                    state_next = spmq_pkg::ST_IDLE;
            end

            spmq_pkg::ST_PUSH:
            begin
                if (out_free)
                begin
                    if (push_ok)
                    begin
                        lvl_op = spmq_pkg::LOP_PUSH;
                        mem_we = 1'b1;
                    end
                    out_load           = 1'b1;
                    push_accepted_next = push_ok;
                    popped_event_next  = '0;
                    pop_valid_next     = 1'b0;
                    last_next          = 1'b1;
                    occupancy_next     = status.total + TOT_W'(push_ok);
                    state_next         = spmq_pkg::ST_IDLE;
                end
            end

            spmq_pkg::ST_POP_READ:
            begin
                if (out_free)
                begin
                    if (status.total == '0)
                    begin
                        out_load           = 1'b1;
                        push_accepted_next = 1'b0;
                        popped_event_next  = '0;
                        pop_valid_next     = 1'b0;
                        last_next          = 1'b1;
                        occupancy_next     = status.total;
                        state_next         = spmq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        lvl_op         = spmq_pkg::LOP_POP;
                        mem_re         = 1'b1;
                        // last when the count runs out or the queue drains
                        last_pend_next = (rem_reg == CNT_W'(1)) ||
                                         (status.total == TOT_W'(1));
                        rem_next       = rem_reg - 1'b1;
                        state_next     = spmq_pkg::ST_POP_LOAD;
                    end
                end
            end

            spmq_pkg::ST_POP_LOAD:
            begin
                out_load           = 1'b1;
                push_accepted_next = 1'b0;
                popped_event_next  = spmq_pkg::OUT_EV_W'(64'(rd_data));
                pop_valid_next     = 1'b1;
                last_next          = last_pend_reg;
                occupancy_next     = status.total;
                state_next         = last_pend_reg ? spmq_pkg::ST_IDLE : spmq_pkg::ST_POP_READ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spmq_pkg::ST_IDLE;
            flush_ptr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flush_ptr_reg <= flush_ptr_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        ev_reg            <= ev_next;
        lvl_reg           <= lvl_next;
        rem_reg           <= rem_next;
        last_pend_reg     <= last_pend_next;
        push_accepted_reg <= push_accepted_next;
        popped_event_reg  <= popped_event_next;
        pop_valid_reg     <= pop_valid_next;
        last_reg          <= last_next;
        occupancy_reg     <= occupancy_next;
    end

    assign out_valid     = out_valid_reg;
    assign push_accepted = push_accepted_reg;
    assign popped_event  = popped_event_reg;
    assign pop_valid     = pop_valid_reg;
    assign last          = last_reg;
    assign occupancy     = occupancy_reg;

    // the op register steers nothing; the next state at accept comes from the operation input; keep it observable here
    a_push_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spmq_pkg::ST_PUSH) |-> (op_reg == spmq_pkg::OP_PUSH))
        else $error("push state entered for a pop request");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spmq_pkg::ST_POP_LOAD) |-> !out_valid_reg)
        else $error("read data arrived while output register still occupied");

    a_flush_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spmq_pkg::ST_FLUSH) |-> (32'(flush_ptr_reg) < MAX_LEVELS))
        else $error("flush pointer beyond last level");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (lvl_op == spmq_pkg::LOP_POP) |-> (status.total != '0 && sel_fill != '0))
        else $error("pop issued on an empty level");

endmodule
